>>> rtl/occupancy_service_controller_top_macros.svh
// Assertion macros for the occupancy service controller.
`ifndef OCCUPANCY_SERVICE_CONTROLLER_TOP_MACROS_SVH
`define OCCUPANCY_SERVICE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("osc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("osc next-cycle check failed");

`endif

>>> rtl/osc_pkg.sv
// Package: item types, register indexes and constants of the occupancy service controller.
`default_nettype none

package osc_pkg;

  localparam int unsigned BUTTON_COUNT = 5;
  localparam int unsigned BUTTON_W     = 5;

  localparam logic [BUTTON_W-1:0] BUTTON_MASK =
    BUTTON_W'((9'd1 << BUTTON_COUNT) - 9'd1);

  localparam logic [7:0] BYTE_OFFSET = 8'd33;
  localparam logic [7:0] SEPARATOR   = 8'h5F;
  localparam logic [7:0] CMD_LIVE    = 8'h73;
  localparam logic [7:0] CMD_SAVED   = 8'h74;

  localparam logic [7:0]  BUILDING_RST      = 8'd65;
  localparam logic [7:0]  ROOM_RST          = 8'd8;
  localparam logic [15:0] TIMEOUT_RST       = 16'd2;
  localparam logic [7:0]  INIT_SERVICES_RST = 8'hFF;

  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    REG_BUILDING      = 2'd0,
    REG_ROOM          = 2'd1,
    REG_TIMEOUT       = 2'd2,
    REG_INIT_SERVICES = 2'd3
  } osc_reg_t;

  typedef enum logic [1:0] {
    FCMD_LOAD  = 2'd0,
    FCMD_LIVE  = 2'd1,
    FCMD_SAVED = 2'd2
  } osc_cmd_t;

  typedef struct packed {
    logic                op;
    logic                motion;
    logic                tick;
    logic [BUTTON_W-1:0] buttons;
    logic [7:0]          frame_building;
    logic [7:0]          frame_room;
    logic [7:0]          frame_command;
    logic [7:0]          frame_separator;
  } osc_in_t;

  typedef struct packed {
    logic [7:0] services;
    logic       inactive;
    logic       reply_valid;
    logic [7:0] reply_building;
    logic [7:0] reply_room;
    logic [7:0] reply_status;
    logic [7:0] reply_idle;
  } osc_out_t;

  typedef struct packed {
    logic       hit;
    osc_cmd_t   cmd;
    logic [7:0] room_byte;
  } osc_frame_t;

endpackage

`default_nettype wire

>>> rtl/osc_frame_dec.sv
// Frame address check and command decode.
`default_nettype none

module osc_frame_dec (
  input  wire osc_pkg::osc_in_t    item,
  input  wire logic [7:0]          building_code,
  input  wire logic [7:0]          room_number,
  output osc_pkg::osc_frame_t      frame
);

  always_comb begin
    frame.room_byte = room_number + osc_pkg::BYTE_OFFSET;
    frame.hit = (item.frame_building == building_code) &&
                (item.frame_room == frame.room_byte) &&
                (item.frame_separator == osc_pkg::SEPARATOR);
    if (item.frame_command == osc_pkg::CMD_LIVE) begin
      frame.cmd = osc_pkg::FCMD_LIVE;
    end else if (item.frame_command == osc_pkg::CMD_SAVED) begin
      frame.cmd = osc_pkg::FCMD_SAVED;
    end else begin
      frame.cmd = osc_pkg::FCMD_LOAD;
    end
  end

endmodule

`default_nettype wire

>>> rtl/osc_state.sv
// Service state registers, idle counter and per-item result logic.
`default_nettype none

module osc_state (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire osc_pkg::osc_in_t    item,
  input  wire osc_pkg::osc_frame_t frame,
  input  wire logic [7:0]          building_code,
  input  wire logic [15:0]         timeout_ticks,
  output logic                     idle_flag,
  output logic [7:0]               live_services,
  output osc_pkg::osc_out_t        result
);

  logic [7:0]  live_r, live_nxt;
  logic [7:0]  saved_r, saved_nxt;
  logic        flag_r, flag_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] cnt_inc;
  logic [7:0]  press;
  logic        reply;
  logic [7:0]  status;

  always_comb begin
    live_nxt  = live_r;
    saved_nxt = saved_r;
    flag_nxt  = flag_r;
    cnt_nxt   = cnt_r;
    reply     = 1'b0;
    status    = 8'd0;
    cnt_inc   = cnt_r + 16'd1;
    press     = {{(8 - osc_pkg::BUTTON_W){1'b0}}, item.buttons & osc_pkg::BUTTON_MASK};
    if (!item.op) begin
      if (press != 8'd0) begin
        live_nxt  = live_r ^ press;
        saved_nxt = live_r ^ press;
        flag_nxt  = 1'b0;
        cnt_nxt   = 16'd0;
      end else if (!item.motion && item.tick && (cnt_r < timeout_ticks)) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == timeout_ticks) begin
          flag_nxt  = 1'b1;
          saved_nxt = live_r;
          live_nxt  = 8'd0;
        end
      end
      // motion wins: restore saved services
      if (item.motion) begin
        flag_nxt = 1'b0;
        cnt_nxt  = 16'd0;
        live_nxt = saved_nxt;
      end
    end else if (frame.hit) begin
      unique case (frame.cmd)
        osc_pkg::FCMD_LIVE: begin
          reply  = 1'b1;
          status = live_r + osc_pkg::BYTE_OFFSET;
        end
        osc_pkg::FCMD_SAVED: begin
          reply  = 1'b1;
          status = saved_r + osc_pkg::BYTE_OFFSET;
        end
        default: begin
          live_nxt  = item.frame_command - osc_pkg::BYTE_OFFSET;
          saved_nxt = item.frame_command - osc_pkg::BYTE_OFFSET;
          flag_nxt  = 1'b0;
          cnt_nxt   = 16'd0;
        end
      endcase
    end
  end

  always_comb begin
    result.services       = live_nxt;
    result.inactive       = flag_nxt;
    result.reply_valid    = reply;
    result.reply_building = reply ? building_code : 8'd0;
    result.reply_room     = reply ? frame.room_byte : 8'd0;
    result.reply_status   = status;
    result.reply_idle     = reply ? ({7'd0, flag_nxt} + osc_pkg::BYTE_OFFSET) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= osc_pkg::INIT_SERVICES_RST;
      saved_r <= osc_pkg::INIT_SERVICES_RST;
      flag_r  <= 1'b0;
      cnt_r   <= 16'd0;
    end else if (advance) begin
      live_r  <= live_nxt;
      saved_r <= saved_nxt;
      flag_r  <= flag_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign idle_flag     = flag_r;
  assign live_services = live_r;

endmodule

`default_nettype wire

>>> rtl/occupancy_service_controller_top.sv
// Top level of the occupancy service controller: channels, config registers, pipeline.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one item: a poll (op = 0) with
//   motion level, timer tick and toggle buttons, or a serial frame (op = 1).
//   Result channel out_valid/out_ready/out_data returns exactly one item per input
//   item: live services, inactivity flag and an optional status reply frame.
//   Configuration port cfg_we/cfg_index/cfg_data writes building code, room number,
//   timeout ticks and initial services; write only while no item is in flight.
// Flow: an accepted item sits in the input register; its result is loaded into the
//   output register once that register is free, and out_valid then shows it to the
//   receiver. Throughput is one item per cycle while out_ready stays high; the state
//   update is a single pass of logic.
// Reset (rst_n low, synchronous): both pipeline stages empty, config registers back
//   to their defaults, live and saved services to all ones, idle count and flag clear.
//   Initial services therefore always reset to all ones, so writes to it have no
//   visible effect and are dropped.
// Stall: while out_ready is low a held result blocks the input register, and in_ready
//   drops once both stages are full; nothing is lost or repeated.
`default_nettype none
`include "occupancy_service_controller_top_macros.svh"

module occupancy_service_controller_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire osc_pkg::osc_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output osc_pkg::osc_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire osc_pkg::osc_reg_t                 cfg_index,
  input  wire logic [osc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Config registers
  logic [7:0]  building_r;
  logic [7:0]  room_r;
  logic [15:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      building_r <= osc_pkg::BUILDING_RST;
      room_r     <= osc_pkg::ROOM_RST;
      timeout_r  <= osc_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        osc_pkg::REG_BUILDING: building_r <= cfg_data[7:0];
        osc_pkg::REG_ROOM:     room_r     <= cfg_data[7:0];
        osc_pkg::REG_TIMEOUT:  timeout_r  <= cfg_data[15:0];
        default: begin
          // initial services: reset restores the default, drop the write
        end
      endcase
    end
  end

  // Pipeline control: the result register frees when taken, the input register
  // advances into a free result register.
  logic               in_vld_r;
  osc_pkg::osc_in_t   in_data_r;
  logic               out_vld_r;
  osc_pkg::osc_out_t  out_data_r;
  logic               out_free;
  logic               advance;

  assign out_free = !out_vld_r || out_ready;
  assign advance  = in_vld_r && out_free;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // Payload needs no reset; load only on acceptance.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Frame decode and state update on the item in the input register.
  osc_pkg::osc_frame_t frame;
  osc_pkg::osc_out_t   result;
  logic                idle_flag;
  logic [7:0]          live_services;

  osc_frame_dec u_frame_dec (
    .item          (in_data_r),
    .building_code (building_r),
    .room_number   (room_r),
    .frame         (frame)
  );

  osc_state u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .item          (in_data_r),
    .frame         (frame),
    .building_code (building_r),
    .timeout_ticks (timeout_r),
    .idle_flag     (idle_flag),
    .live_services (live_services),
    .result        (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Checks
  `OSC_ASSERT_IMP(a_idle_means_off, idle_flag, live_services == 8'd0)
  `OSC_ASSERT_NXT(a_stall_holds_input, in_vld_r && !out_free,
                  in_vld_r && $stable(in_data_r))
  `OSC_ASSERT_IMP(a_reply_idle_tracks_flag, out_vld_r && out_data_r.reply_valid,
                  out_data_r.reply_idle == (osc_pkg::BYTE_OFFSET + 8'(out_data_r.inactive)))

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the occupancy service controller top level.
module tb;
  import osc_pkg::*;

  // Stop when no item moves on either channel for this many cycles.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Room for the two-stage pipeline plus margin at the end of the run.
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned ITEMS_PER_PHASE = 260;
  localparam logic [7:0]  POLL_MASK      = 8'((9'd1 << BUTTON_COUNT) - 9'd1);

  // Receiver stall patterns, swapped at random intervals.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_RHYTHM
  } rx_mode_t;

  // Ways to spoil an otherwise well-formed frame.
  typedef enum logic [1:0] {
    FAULT_BUILDING,
    FAULT_ROOM,
    FAULT_SEPARATOR,
    FAULT_GARBAGE
  } frame_fault_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  osc_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  osc_out_t  out_data;
  logic      cfg_we = 1'b0;
  osc_reg_t  cfg_index = REG_BUILDING;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  occupancy_service_controller_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register copies held by the predictor; they follow every cfg write.
  logic [7:0]  building_code    = BUILDING_RST;
  logic [7:0]  room_number      = ROOM_RST;
  logic [15:0] timeout_ticks    = TIMEOUT_RST;
  logic [7:0]  initial_services = INIT_SERVICES_RST;

  // Controller state as predicted. Reset happens once, so the initial
  // services value seen here is the one in force at that reset.
  logic [7:0]  live_services  = INIT_SERVICES_RST;
  logic [7:0]  saved_services = INIT_SERVICES_RST;
  logic        idle_flag      = 1'b0;
  logic [15:0] idle_count     = '0;

  osc_in_t  pending_items[$];
  osc_out_t expected_results[$];
  int unsigned fail_count = 0;
  bit item_taken = 1'b0;

  // Sender burst/gap bookkeeping.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Receiver stall bookkeeping.
  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_beat      = 0;

  int unsigned quiet_cycles = 0;

  // Advance the predicted state by one item and form its result.
  task automatic predict_result(input osc_in_t item, output osc_out_t res);
    logic [7:0] room_byte;
    logic [7:0] press;
    logic [7:0] status;
    logic       reply;
    room_byte = room_number + BYTE_OFFSET;
    reply = 1'b0;
    status = '0;
    if (!item.op) begin
      press = {3'b000, item.buttons} & POLL_MASK;
      if (press != '0) begin
        // A press toggles, wakes the room and consumes this poll's tick.
        live_services  = live_services ^ press;
        idle_flag      = 1'b0;
        idle_count     = '0;
        saved_services = live_services;
      end else if (!item.motion && item.tick) begin
        // Saturate at the timeout so switch-off fires once per idle run.
        if (idle_count < timeout_ticks) begin
          idle_count = idle_count + 16'd1;
          if (idle_count == timeout_ticks) begin
            idle_flag      = 1'b1;
            saved_services = live_services;
            live_services  = '0;
          end
        end
      end
      if (item.motion) begin
        idle_flag     = 1'b0;
        idle_count    = '0;
        live_services = saved_services;
      end
    end else if (item.frame_building == building_code && item.frame_room == room_byte &&
                 item.frame_separator == SEPARATOR) begin
      if (item.frame_command == CMD_LIVE) begin
        reply  = 1'b1;
        status = live_services + BYTE_OFFSET;
      end else if (item.frame_command == CMD_SAVED) begin
        reply  = 1'b1;
        status = saved_services + BYTE_OFFSET;
      end else begin
        live_services  = item.frame_command - BYTE_OFFSET;
        saved_services = live_services;
        idle_flag      = 1'b0;
        idle_count     = '0;
      end
    end
    res = '0;
    res.services = live_services;
    res.inactive = idle_flag;
    if (reply) begin
      res.reply_valid    = 1'b1;
      res.reply_building = building_code;
      res.reply_room     = room_byte;
      res.reply_status   = status;
      res.reply_idle     = {7'd0, idle_flag} + BYTE_OFFSET;
    end
  endtask

  // Compare one result field; print and count every mismatch.
  task automatic check_field(input string field, input int unsigned got,
                             input int unsigned want);
    if (got !== want) begin
      fail_count++;
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    end
  endtask

  function automatic osc_in_t make_poll(input logic motion, input logic tick,
                                        input logic [BUTTON_W-1:0] buttons);
    osc_in_t item;
    item = osc_in_t'($bits(osc_in_t)'({$urandom, $urandom}));
    item.op      = 1'b0;
    item.motion  = motion;
    item.tick    = tick;
    item.buttons = buttons;
    return item;
  endfunction

  function automatic osc_in_t make_frame(input logic [7:0] bld, input logic [7:0] room,
                                         input logic [7:0] cmd, input logic [7:0] sep);
    osc_in_t item;
    item = osc_in_t'($bits(osc_in_t)'({$urandom, $urandom}));
    item.op              = 1'b1;
    item.frame_building  = bld;
    item.frame_room      = room;
    item.frame_command   = cmd;
    item.frame_separator = sep;
    return item;
  endfunction

  // Mostly idle-timer polls and frames addressed to this room; some noise.
  function automatic osc_in_t random_item();
    osc_in_t item;
    int unsigned pick;
    logic [7:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      item = make_poll($urandom_range(0, 9) == 0, $urandom_range(0, 9) < 7,
                       ($urandom_range(0, 7) == 0) ? BUTTON_W'($urandom) : '0);
    end else begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_LIVE;
        1:       cmd = CMD_SAVED;
        default: cmd = 8'($urandom);
      endcase
      item = make_frame(building_code, room_number + BYTE_OFFSET, cmd, SEPARATOR);
      if (pick >= 90) begin
        case (frame_fault_t'($urandom_range(0, 3)))
          FAULT_BUILDING:  item.frame_building  ^= 8'($urandom_range(1, 255));
          FAULT_ROOM:      item.frame_room      ^= 8'($urandom_range(1, 255));
          FAULT_SEPARATOR: item.frame_separator ^= 8'($urandom_range(1, 255));
          default:         item = osc_in_t'($bits(osc_in_t)'({$urandom, $urandom}));
        endcase
        item.op = 1'b1;
      end
    end
    return item;
  endfunction

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_items.push_back(random_item());
  endtask

  // Write one register while the block is idle and track it in the predictor.
  task automatic write_register(input osc_reg_t idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    case (idx)
      REG_BUILDING:      building_code    = 8'(value);
      REG_ROOM:          room_number      = 8'(value);
      REG_TIMEOUT:       timeout_ticks    = 16'(value);
      REG_INIT_SERVICES: initial_services = 8'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input int unsigned bld, input int unsigned room,
                           input int unsigned tmo, input int unsigned init);
    write_register(REG_BUILDING, bld);
    write_register(REG_ROOM, room);
    write_register(REG_TIMEOUT, tmo);
    write_register(REG_INIT_SERVICES, init);
  endtask

  // Hold until no item is queued, presented or in flight, then a short margin.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sender: present queued items in bursts of random length, with random
  // gaps between bursts. Change inputs only on the falling edge.
  always @(negedge clk) begin
    logic    next_valid;
    osc_in_t next_data;
    next_valid = in_valid;
    next_data  = in_data;
    if (rst_n) begin
      // Drop the item once the rising edge has taken it.
      if (in_valid && item_taken) next_valid = 1'b0;
      item_taken = 1'b0;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          next_data  = pending_items.pop_front();
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
    in_valid <= next_valid;
    in_data  <= next_data;
  end

  // Receiver: stall on a pattern that changes at random intervals.
  always @(negedge clk) begin
    logic ready;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    rx_beat++;
    case (rx_mode)
      RX_OPEN:   ready = 1'b1;
      RX_COIN:   ready = 1'($urandom_range(0, 1));
      RX_SPARSE: ready = ($urandom_range(0, 3) == 0);
      default:   ready = (rx_beat % 5) != 0;
    endcase
    out_ready <= ready;
  end

  // Monitor: predict on every accepted item, check every accepted result
  // against the oldest expectation.
  always @(posedge clk) begin
    osc_out_t res;
    osc_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_result(in_data, res);
        expected_results.push_back(res);
        item_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          check_field("result with nothing pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          check_field("services",       out_data.services,       want.services);
          check_field("inactive",       out_data.inactive,       want.inactive);
          check_field("reply_valid",    out_data.reply_valid,    want.reply_valid);
          check_field("reply_building", out_data.reply_building, want.reply_building);
          check_field("reply_room",     out_data.reply_room,     want.reply_room);
          check_field("reply_status",   out_data.reply_status,   want.reply_status);
          check_field("reply_idle",     out_data.reply_idle,     want.reply_idle);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [7:0] room_byte;
    // Hold reset from the start, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings.
    room_byte = ROOM_RST + BYTE_OFFSET;
    pending_items.push_back(make_poll(1'b0, 1'b0, '0));
    // Two idle ticks reach the timeout; the third must not retrigger.
    pending_items.push_back(make_poll(1'b0, 1'b1, '0));
    pending_items.push_back(make_poll(1'b0, 1'b1, '0));
    pending_items.push_back(make_poll(1'b0, 1'b1, '0));
    // Status while switched off: live + 33 and saved + 33 with wrap.
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, CMD_LIVE, SEPARATOR));
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, CMD_SAVED, SEPARATOR));
    // Motion restores the saved services.
    pending_items.push_back(make_poll(1'b1, 1'b1, '0));
    // All buttons at once, tick consumed by the press.
    pending_items.push_back(make_poll(1'b0, 1'b1, '1));
    pending_items.push_back(make_poll(1'b1, 1'b0, BUTTON_W'(1)));
    // Load commands at both byte extremes; 0 - 33 wraps.
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, 8'h00, SEPARATOR));
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, CMD_SAVED, SEPARATOR));
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, 8'hFF, SEPARATOR));
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, CMD_LIVE, SEPARATOR));
    // Frames for another building, room or with a bad separator are ignored.
    pending_items.push_back(make_frame(8'h00, room_byte, CMD_LIVE, SEPARATOR));
    pending_items.push_back(make_frame(BUILDING_RST, 8'hFF, CMD_LIVE, SEPARATOR));
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, CMD_LIVE, 8'h00));
    pending_items.push_back(make_frame(8'hFF, 8'h00, 8'hFF, 8'hFF));
    // Time out again after a load, then wake the room with the top button.
    pending_items.push_back(make_poll(1'b0, 1'b1, '0));
    pending_items.push_back(make_poll(1'b0, 1'b1, '0));
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, CMD_SAVED, SEPARATOR));
    pending_items.push_back(make_poll(1'b0, 1'b0, BUTTON_W'(5'h10)));
    pending_items.push_back(make_frame(BUILDING_RST, room_byte, CMD_LIVE, SEPARATOR));
    queue_random(ITEMS_PER_PHASE);

    // Each phase waits for every result first, so the sender pauses here.
    wait_drained();
    write_all(0, 0, 1, 0);
    queue_random(ITEMS_PER_PHASE);

    wait_drained();
    write_all(255, 222, 3, 255);
    queue_random(ITEMS_PER_PHASE);

    // Largest timeout: the idle run never completes.
    wait_drained();
    write_all($urandom_range(0, 255), $urandom_range(0, 222), 65535, $urandom_range(0, 255));
    queue_random(ITEMS_PER_PHASE);

    // Zero timeout: services never switch off.
    wait_drained();
    write_all($urandom_range(0, 255), $urandom_range(0, 222), 0, $urandom_range(0, 255));
    queue_random(ITEMS_PER_PHASE);

    wait_drained();
    write_all($urandom_range(0, 255), $urandom_range(0, 222), $urandom_range(1, 8),
              $urandom_range(0, 255));
    queue_random(ITEMS_PER_PHASE);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/osc_pkg.sv
rtl/osc_frame_dec.sv
rtl/osc_state.sv
rtl/occupancy_service_controller_top.sv
tb/sv/tb.sv
